@@ hdl/pdtf_pkg.sv @@
package pdtf_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int KEY_W    = 13;
  localparam int TIME_W   = 19;
  localparam int DEAD_W   = 16;
  localparam int STRIP_W  = 13;
  localparam int CHIP_W   = 7;
  localparam int BOARD_W  = 10;
  localparam int CHARGE_W = 16;
  localparam int ENTRY_W  = KEY_W + TIME_W;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [1:0] REG_KEY_MODE     = 2'd0;
  localparam logic [1:0] REG_STRIP_DEAD   = 2'd1;
  localparam logic [1:0] REG_TRIGGER_DEAD = 2'd2;

  typedef struct packed {
    logic                      event_start;
    logic [KEY_W-1:0]          key;
    logic [DEAD_W-1:0]         dead;
    logic [STRIP_W-1:0]        strip_position;
    logic [CHIP_W-1:0]         chip_id;
    logic [BOARD_W-1:0]        board_chip_id;
    logic signed [TIME_W-1:0]  hit_time;
    logic [CHARGE_W-1:0]       hit_charge;
  } hit_item_t;

  typedef struct packed {
    logic             idle;
    logic [CNT_W-1:0] count;
  } bk_stat_t;

endpackage

@@ hdl/pdtf_ram.sv @@
module pdtf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/pdtf_front.sv @@
module pdtf_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_event_start,
  input  logic [pdtf_pkg::STRIP_W-1:0]        in_strip_position,
  input  logic [pdtf_pkg::CHIP_W-1:0]         in_chip_id,
  input  logic [pdtf_pkg::BOARD_W-1:0]        in_board_chip_id,
  input  logic signed [pdtf_pkg::TIME_W-1:0]  in_hit_time,
  input  logic [pdtf_pkg::CHARGE_W-1:0]       in_hit_charge,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pdtf_pkg::APB_AW-1:0]         paddr,
  input  logic [pdtf_pkg::APB_DW-1:0]         pwdata,
  output logic [pdtf_pkg::APB_DW-1:0]         prdata,
  output logic                                pready,
  input  logic                                q_full,
  output logic                                push,
  output pdtf_pkg::hit_item_t                 push_item
);
  import pdtf_pkg::*;

  logic              key_mode_r;
  logic [DEAD_W-1:0] strip_dead_r;
  logic [DEAD_W-1:0] trig_dead_r;
  logic [1:0]        reg_idx;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_mode_r   <= 1'b0;
      strip_dead_r <= '0;
      trig_dead_r  <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_KEY_MODE:     key_mode_r   <= pwdata[0];
        REG_STRIP_DEAD:   strip_dead_r <= pwdata[DEAD_W-1:0];
        REG_TRIGGER_DEAD: trig_dead_r  <= pwdata[DEAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_KEY_MODE:     prdata = {{(APB_DW-1){1'b0}}, key_mode_r};
      REG_STRIP_DEAD:   prdata = {{(APB_DW-DEAD_W){1'b0}}, strip_dead_r};
      REG_TRIGGER_DEAD: prdata = {{(APB_DW-DEAD_W){1'b0}}, trig_dead_r};
      default:          prdata = '0;
    endcase
  end

  // The hit is classified here: the dead-time key and the dead time that
  // apply to it travel with the hit through the queue.
  assign busy = q_full;
  assign push = start && !busy;

  always_comb begin
    push_item.event_start    = in_event_start;
    push_item.key            = key_mode_r ?
                               {{(KEY_W-CHIP_W){1'b0}}, in_chip_id} : in_strip_position;
    push_item.dead           = key_mode_r ? trig_dead_r : strip_dead_r;
    push_item.strip_position = in_strip_position;
    push_item.chip_id        = in_chip_id;
    push_item.board_chip_id  = in_board_chip_id;
    push_item.hit_time       = in_hit_time;
    push_item.hit_charge     = in_hit_charge;
  end

endmodule

@@ hdl/pdtf_queue.sv @@
module pdtf_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pdtf_pkg::hit_item_t push_item,
  input  logic                pop,
  output pdtf_pkg::hit_item_t pop_item,
  output logic                full,
  output logic                empty
);
  import pdtf_pkg::*;

  hit_item_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign full     = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

@@ hdl/pdtf_back.sv @@
module pdtf_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_empty,
  input  pdtf_pkg::hit_item_t                 q_item,
  output logic                                pop,
  output logic                                out_valid,
  output logic [pdtf_pkg::STRIP_W-1:0]        out_strip_position,
  output logic [pdtf_pkg::CHIP_W-1:0]         out_chip_id,
  output logic [pdtf_pkg::BOARD_W-1:0]        out_board_chip_id,
  output logic signed [pdtf_pkg::TIME_W-1:0]  out_time,
  output logic [pdtf_pkg::CHARGE_W-1:0]       out_charge,
  output logic                                out_table_overflow,
  output pdtf_pkg::bk_stat_t                  stat
);
  import pdtf_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  state_t                    state_r;
  hit_item_t                 item_r;
  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          idx_r;
  logic                      cmp_vld_r;
  logic                      out_valid_r;
  logic [STRIP_W-1:0]        out_strip_r;
  logic [CHIP_W-1:0]         out_chip_r;
  logic [BOARD_W-1:0]        out_board_r;
  logic signed [TIME_W-1:0]  out_time_r;
  logic [CHARGE_W-1:0]       out_charge_r;
  logic                      out_ovf_r;

  logic                      rd_en;
  logic                      wr_en;
  logic                      room;
  logic                      done;
  logic                      match;
  logic [ENTRY_W-1:0]        rd_data;
  logic [KEY_W-1:0]          ent_key;
  logic signed [TIME_W-1:0]  ent_time;
  logic [TIME_W:0]           diff;

  assign room  = (count_r < CNT_W'(TABLE_DEPTH));
  assign pop   = (state_r == ST_IDLE) && !q_empty;
  assign rd_en = (state_r == ST_WALK) && (idx_r < count_r);
  assign done  = (state_r == ST_WALK) && !rd_en && !cmp_vld_r;
  assign wr_en = done && room;

  pdtf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count_r[IDX_W-1:0]),
    .wdata ({item_r.key, item_r.hit_time}),
    .re    (rd_en),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (rd_data)
  );

  assign ent_key  = rd_data[ENTRY_W-1:TIME_W];
  assign ent_time = $signed(rd_data[TIME_W-1:0]);

  // An entry kills the hit only if it is strictly earlier, so the difference
  // is positive and fits in TIME_W bits as an unsigned value.
  assign diff  = {item_r.hit_time[TIME_W-1], item_r.hit_time}
               - {ent_time[TIME_W-1], ent_time};
  assign match = cmp_vld_r && (ent_key == item_r.key) && (ent_time < item_r.hit_time)
              && (diff < {{(TIME_W + 1 - DEAD_W){1'b0}}, item_r.dead});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      cmp_vld_r   <= rd_en;
      case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            item_r <= q_item;
            idx_r  <= '0;
            if (q_item.event_start) begin
              count_r <= '0;
            end
            state_r <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (rd_en) begin
            idx_r <= idx_r + 1'b1;
          end
          if (match) begin
            cmp_vld_r <= 1'b0;
            state_r   <= ST_IDLE;
          end else if (done) begin
            out_valid_r  <= 1'b1;
            out_strip_r  <= item_r.strip_position;
            out_chip_r   <= item_r.chip_id;
            out_board_r  <= item_r.board_chip_id;
            out_time_r   <= item_r.hit_time;
            out_charge_r <= item_r.hit_charge;
            out_ovf_r    <= !room;
            if (room) begin
              count_r <= count_r + 1'b1;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_strip_position = out_strip_r;
  assign out_chip_id        = out_chip_r;
  assign out_board_chip_id  = out_board_r;
  assign out_time           = out_time_r;
  assign out_charge         = out_charge_r;
  assign out_table_overflow = out_ovf_r;
  assign stat.idle          = (state_r == ST_IDLE);
  assign stat.count         = count_r;

endmodule

@@ hdl/per_channel_dead_time_filter.sv @@
// Channel   Handshake                      Payload
// input     start / busy                   in_event_start, in_strip_position, in_chip_id,
//                                          in_board_chip_id, in_hit_time, in_hit_charge
// result    out_valid (one-cycle strobe)   out_strip_position, out_chip_id, out_board_chip_id,
//                                          out_time, out_charge, out_table_overflow
// config    psel / penable / pready        paddr, pwdata, prdata
//
// In the back end a hit walks the N table entries recorded so far in the event
// (at most TABLE_DEPTH), with one table RAM read per entry.
// A hit killed by an entry leaves as soon as that entry is compared.
// A four-entry queue holds classified hits; busy is high only while it is full.
// rst_n is synchronous; it clears the configuration registers, the queue and the entry count.
// Results cannot be stalled: each is shown for exactly one cycle.
module per_channel_dead_time_filter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_event_start,
  input  logic [pdtf_pkg::STRIP_W-1:0]        in_strip_position,
  input  logic [pdtf_pkg::CHIP_W-1:0]         in_chip_id,
  input  logic [pdtf_pkg::BOARD_W-1:0]        in_board_chip_id,
  input  logic signed [pdtf_pkg::TIME_W-1:0]  in_hit_time,
  input  logic [pdtf_pkg::CHARGE_W-1:0]       in_hit_charge,
  output logic                                out_valid,
  output logic [pdtf_pkg::STRIP_W-1:0]        out_strip_position,
  output logic [pdtf_pkg::CHIP_W-1:0]         out_chip_id,
  output logic [pdtf_pkg::BOARD_W-1:0]        out_board_chip_id,
  output logic signed [pdtf_pkg::TIME_W-1:0]  out_time,
  output logic [pdtf_pkg::CHARGE_W-1:0]       out_charge,
  output logic                                out_table_overflow,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pdtf_pkg::APB_AW-1:0]         paddr,
  input  logic [pdtf_pkg::APB_DW-1:0]         pwdata,
  output logic [pdtf_pkg::APB_DW-1:0]         prdata,
  output logic                                pready
);
  import pdtf_pkg::*;

  logic      q_full;
  logic      q_empty;
  logic      push;
  logic      pop;
  hit_item_t push_item;
  hit_item_t pop_item;
  bk_stat_t  stat;

  pdtf_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_event_start    (in_event_start),
    .in_strip_position (in_strip_position),
    .in_chip_id        (in_chip_id),
    .in_board_chip_id  (in_board_chip_id),
    .in_hit_time       (in_hit_time),
    .in_hit_charge     (in_hit_charge),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .q_full            (q_full),
    .push              (push),
    .push_item         (push_item)
  );

  pdtf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  pdtf_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_item             (pop_item),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_strip_position (out_strip_position),
    .out_chip_id        (out_chip_id),
    .out_board_chip_id  (out_board_chip_id),
    .out_time           (out_time),
    .out_charge         (out_charge),
    .out_table_overflow (out_table_overflow),
    .stat               (stat)
  );

  // Each hit passes through the idle and walk states in the back end, so results never come back to back.
  a_no_back_to_back_results: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results in consecutive cycles");

  a_overflow_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_table_overflow) |-> (stat.count == CNT_W'(TABLE_DEPTH)))
    else $error("overflow flagged while the table has room");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    stat.count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_result_from_back_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(!stat.idle))
    else $error("result without a hit in the back end");

endmodule

@@ verif/per_channel_dead_time_filter_tb.sv @@
module per_channel_dead_time_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pdtf_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 9;
  localparam int CYCLE_LIMIT   = 1_000_000;
  // Enough for four queued hits plus one in the back end, each walking up to TABLE_DEPTH entries.
  localparam int SETTLE_CYCLES = 6 * (TABLE_DEPTH + 2);
  localparam int PHASE_HITS    = 280;
  localparam int NUM_PHASES    = 6;

  typedef struct {
    logic                     event_start;
    logic [STRIP_W-1:0]       strip;
    logic [CHIP_W-1:0]        chip;
    logic [BOARD_W-1:0]       board;
    logic signed [TIME_W-1:0] hit_time;
    logic [CHARGE_W-1:0]      charge;
  } hit_t;

  typedef struct {
    logic [STRIP_W-1:0]       strip;
    logic [CHIP_W-1:0]        chip;
    logic [BOARD_W-1:0]       board;
    logic signed [TIME_W-1:0] hit_time;
    logic [CHARGE_W-1:0]      charge;
    logic                     overflow;
  } passed_hit_t;

  typedef enum { ROW_HIT, ROW_CFG } row_kind_t;
  typedef enum { CHK_MODEL, CHK_PASS, CHK_DROP } row_check_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  reg_idx;
    logic [31:0] value;
    hit_t        hit;
    row_check_t  check;
  } stim_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     in_event_start = 1'b0;
  logic [STRIP_W-1:0]       in_strip_position = '0;
  logic [CHIP_W-1:0]        in_chip_id = '0;
  logic [BOARD_W-1:0]       in_board_chip_id = '0;
  logic signed [TIME_W-1:0] in_hit_time = '0;
  logic [CHARGE_W-1:0]      in_hit_charge = '0;
  logic                     out_valid;
  logic [STRIP_W-1:0]       out_strip_position;
  logic [CHIP_W-1:0]        out_chip_id;
  logic [BOARD_W-1:0]       out_board_chip_id;
  logic signed [TIME_W-1:0] out_time;
  logic [CHARGE_W-1:0]      out_charge;
  logic                     out_table_overflow;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_AW-1:0]        paddr = '0;
  logic [APB_DW-1:0]        pwdata = '0;
  logic [APB_DW-1:0]        prdata;
  logic                     pready;

  // Shadow copy of the configuration and of the accepted-hit table.
  logic                     chip_keyed = 1'b0;
  logic [DEAD_W-1:0]        strip_dead = '0;
  logic [DEAD_W-1:0]        trig_dead = '0;
  logic [KEY_W-1:0]         seen_key [TABLE_DEPTH];
  int                       seen_time [TABLE_DEPTH];
  int                       seen_count = 0;

  stim_row_t                rows [$];
  passed_hit_t              hits_expected [$];
  passed_hit_t              want_hit;
  int                       errors = 0;
  int                       hits_sent = 0;

  per_channel_dead_time_filter uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_event_start     (in_event_start),
    .in_strip_position  (in_strip_position),
    .in_chip_id         (in_chip_id),
    .in_board_chip_id   (in_board_chip_id),
    .in_hit_time        (in_hit_time),
    .in_hit_charge      (in_hit_charge),
    .out_valid          (out_valid),
    .out_strip_position (out_strip_position),
    .out_chip_id        (out_chip_id),
    .out_board_chip_id  (out_board_chip_id),
    .out_time           (out_time),
    .out_charge         (out_charge),
    .out_table_overflow (out_table_overflow),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Decides whether a hit survives the dead time and updates the shadow table.
  function automatic bit dead_time_pass(input hit_t h, output passed_hit_t r);
    logic [KEY_W-1:0] key;
    int               dead;
    int               t;
    if (h.event_start) seen_count = 0;
    key  = chip_keyed ? KEY_W'(h.chip) : KEY_W'(h.strip);
    dead = chip_keyed ? int'(trig_dead) : int'(strip_dead);
    t    = int'(h.hit_time);
    for (int i = 0; i < seen_count; i++) begin
      if (seen_key[i] == key && seen_time[i] < t && t - seen_time[i] < dead) return 1'b0;
    end
    r = '{h.strip, h.chip, h.board, h.hit_time, h.charge, 1'b1};
    if (seen_count < TABLE_DEPTH) begin
      seen_key[seen_count]  = key;
      seen_time[seen_count] = t;
      seen_count++;
      r.overflow = 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic stim_row_t hit_row(input logic es, input int strip, input int chip,
                                        input int board, input int t, input int charge,
                                        input row_check_t check);
    stim_row_t row;
    row.kind             = ROW_HIT;
    row.reg_idx          = REG_KEY_MODE;
    row.value            = '0;
    row.hit.event_start  = es;
    row.hit.strip        = STRIP_W'(strip);
    row.hit.chip         = CHIP_W'(chip);
    row.hit.board        = BOARD_W'(board);
    row.hit.hit_time     = TIME_W'(t);
    row.hit.charge       = CHARGE_W'(charge);
    row.check            = check;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input logic [1:0] idx, input logic [31:0] value);
    stim_row_t row;
    row       = hit_row(1'b0, 0, 0, 0, 0, 0, CHK_MODEL);
    row.kind  = ROW_CFG;
    row.reg_idx = idx;
    row.value = value;
    return row;
  endfunction

  task automatic add_row(input stim_row_t row);
    rows.insert(rows.size(), row);
  endtask

  task automatic expect_hit(input passed_hit_t r);
    hits_expected.insert(hits_expected.size(), r);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (hits_expected.size() == 0) begin
        $display("%0t: unexpected result, strip %h time %h", $time, out_strip_position,
                 out_time);
        errors++;
      end else begin
        want_hit = hits_expected.pop_front();
        check_field("out_strip_position", 32'(want_hit.strip), 32'(out_strip_position));
        check_field("out_chip_id", 32'(want_hit.chip), 32'(out_chip_id));
        check_field("out_board_chip_id", 32'(want_hit.board), 32'(out_board_chip_id));
        check_field("out_time", 32'(want_hit.hit_time), 32'(out_time));
        check_field("out_charge", 32'(want_hit.charge), 32'(out_charge));
        check_field("out_table_overflow", 32'(want_hit.overflow), 32'(out_table_overflow));
      end
    end
  end

  // Presents one hit and holds it until the transaction completes.
  task automatic send_hit(input hit_t h, input row_check_t check);
    passed_hit_t r;
    bit          passes;
    start             <= 1'b1;
    in_event_start    <= h.event_start;
    in_strip_position <= h.strip;
    in_chip_id        <= h.chip;
    in_board_chip_id  <= h.board;
    in_hit_time       <= h.hit_time;
    in_hit_charge     <= h.charge;
    @(posedge clk);
    while (busy) @(posedge clk);
    passes = dead_time_pass(h, r);
    case (check)
      CHK_MODEL: if (passes) expect_hit(r);
      CHK_PASS:  expect_hit('{h.strip, h.chip, h.board, h.hit_time, h.charge, 1'b0});
      default: ;
    endcase
    hits_sent++;
  endtask

  task automatic sender_gap(input int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // A dropped hit leaves no result behind, so the back end may still be walking
  // the table when the last expected result has arrived.
  task automatic wait_idle();
    start <= 1'b0;
    while (hits_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_KEY_MODE:     chip_keyed = value[0];
      REG_STRIP_DEAD:   strip_dead = value[DEAD_W-1:0];
      REG_TRIGGER_DEAD: trig_dead  = value[DEAD_W-1:0];
      default: ;
    endcase
    want = (idx == REG_KEY_MODE) ? {31'b0, value[0]} : {16'b0, value[DEAD_W-1:0]};
    // Read the register back in a second transaction.
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    check_field("prdata", want, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_event(input int idle_pct);
    hit_t               h;
    logic [STRIP_W-1:0] strip_pool [4];
    logic [CHIP_W-1:0]  chip_pool [4];
    int                 n_hits;
    int                 n_keys;
    int                 span;
    int                 t_now;
    int                 pick;
    int                 k;
    int                 r;
    bit                 long_event;
    bit                 noise;
    span = chip_keyed ? int'(trig_dead) : int'(strip_dead);
    pick = $urandom_range(99);
    long_event = (pick < 3);
    noise      = (pick >= 88);
    if (long_event) n_hits = $urandom_range(TABLE_DEPTH + 2, TABLE_DEPTH + 8);
    else if (noise) n_hits = 1;
    else n_hits = $urandom_range(1, 10);
    for (int j = 0; j < 4; j++) begin
      strip_pool[j] = STRIP_W'($urandom_range(0, 8191));
      chip_pool[j]  = CHIP_W'($urandom_range(0, 127));
    end
    n_keys = $urandom_range(1, 4);
    t_now  = $urandom_range(0, 524287) - 262144;
    for (int j = 0; j < n_hits; j++) begin
      k = $urandom_range(0, n_keys - 1);
      h.event_start = (j == 0);
      if (noise) h.event_start = 1'($urandom_range(0, 1));
      if (noise || long_event) begin
        h.strip = STRIP_W'($urandom_range(0, 8191));
        h.chip  = CHIP_W'($urandom_range(0, 127));
      end else begin
        h.strip = strip_pool[k];
        h.chip  = chip_pool[k];
      end
      h.board  = BOARD_W'($urandom_range(0, 1023));
      h.charge = CHARGE_W'($urandom_range(0, 65535));
      r = $urandom_range(99);
      if (r < 25) t_now -= $urandom_range(0, span + 1);
      else if (r >= 40) t_now += $urandom_range(0, span / 2 + 2);
      h.hit_time = TIME_W'(t_now);
      t_now = int'(h.hit_time);
      sender_gap(idle_pct);
      send_hit(h, CHK_MODEL);
    end
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int        phase_base;
    int        idle_pct;

    // Reset configuration: strip keyed, zero dead time.
    add_row(hit_row(1'b1, 0, 0, 0, -262144, 0, CHK_PASS));
    add_row(hit_row(1'b0, 8191, 127, 1023, 262143, 65535, CHK_PASS));
    add_row(hit_row(1'b0, 0, 0, 0, -262143, 0, CHK_PASS));
    add_row(cfg_row(REG_STRIP_DEAD, 32'd100));
    add_row(hit_row(1'b1, 5, 9, 17, 1000, 300, CHK_PASS));
    add_row(hit_row(1'b0, 5, 9, 17, 1050, 301, CHK_DROP));
    add_row(hit_row(1'b0, 5, 9, 17, 1000, 302, CHK_PASS));
    add_row(hit_row(1'b0, 5, 9, 17, 900, 303, CHK_PASS));
    add_row(hit_row(1'b0, 5, 9, 17, 1100, 304, CHK_MODEL));
    add_row(hit_row(1'b0, 6, 9, 17, 1050, 305, CHK_PASS));
    add_row(hit_row(1'b1, 5, 9, 17, 1050, 306, CHK_PASS));
    add_row(cfg_row(REG_STRIP_DEAD, 32'd65535));
    add_row(hit_row(1'b0, 5, 9, 17, 1050 + 65534, 307, CHK_DROP));
    add_row(hit_row(1'b0, 5, 9, 17, 1050 + 65535, 308, CHK_MODEL));
    add_row(cfg_row(REG_KEY_MODE, 32'd1));
    add_row(cfg_row(REG_TRIGGER_DEAD, 32'd65535));
    add_row(hit_row(1'b1, 100, 127, 500, 0, 1, CHK_PASS));
    add_row(hit_row(1'b0, 200, 127, 501, 10, 2, CHK_DROP));
    add_row(hit_row(1'b0, 127, 3, 502, 20, 3, CHK_PASS));
    add_row(hit_row(1'b0, 127, 127, 503, -262144, 4, CHK_PASS));
    add_row(hit_row(1'b0, 300, 127, 504, 262143, 5, CHK_MODEL));
    add_row(cfg_row(REG_TRIGGER_DEAD, 32'd0));
    add_row(hit_row(1'b0, 301, 127, 505, 5, 6, CHK_PASS));
    add_row(cfg_row(REG_KEY_MODE, 32'd0));
    add_row(cfg_row(REG_STRIP_DEAD, 32'd1));
    add_row(hit_row(1'b1, 8191, 0, 1023, 7, 65535, CHK_PASS));
    add_row(hit_row(1'b0, 8191, 0, 1023, 8, 65535, CHK_MODEL));
    add_row(hit_row(1'b0, 8191, 0, 1023, -1, 0, CHK_MODEL));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        wait_idle();
        cfg_write(rows[i].reg_idx, rows[i].value);
      end else begin
        send_hit(rows[i].hit, rows[i].check);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      case (p)
        0: begin
          cfg_write(REG_KEY_MODE, 32'd0);
          cfg_write(REG_STRIP_DEAD, 32'd40);
          cfg_write(REG_TRIGGER_DEAD, 32'd65535);
        end
        1: begin
          cfg_write(REG_KEY_MODE, 32'd1);
          cfg_write(REG_STRIP_DEAD, 32'd65535);
          cfg_write(REG_TRIGGER_DEAD, 32'd300);
        end
        2: begin
          cfg_write(REG_KEY_MODE, 32'd0);
          cfg_write(REG_STRIP_DEAD, 32'd65535);
          cfg_write(REG_TRIGGER_DEAD, 32'd0);
        end
        3: begin
          cfg_write(REG_KEY_MODE, 32'd1);
          cfg_write(REG_STRIP_DEAD, 32'd0);
          cfg_write(REG_TRIGGER_DEAD, 32'd0);
        end
        default: begin
          cfg_write(REG_KEY_MODE, {31'b0, p[0]});
          cfg_write(REG_STRIP_DEAD, $urandom_range(1, 2000));
          cfg_write(REG_TRIGGER_DEAD, $urandom_range(1, 65535));
        end
      endcase
      idle_pct = (p < 2) ? 7 : (p < 4) ? 46 : 0;
      phase_base = hits_sent;
      while (hits_sent < phase_base + PHASE_HITS) random_event(idle_pct);
    end

    wait_idle();
    if (errors == 0 && hits_expected.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
